[rtl/core/sorted_list_engine_core_assert.svh]
// assertion macros for the sorted list engine core
// expects signals named clock and reset in the scope of use
`ifndef SORTED_LIST_ENGINE_CORE_ASSERT_SVH
`define SORTED_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked in and out of reset
`define SLEC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
// checked only outside reset
`define SLEC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`else
`define SLEC_ASSERT_ALWAYS(lbl, prop, msg)
`define SLEC_ASSERT(lbl, prop, msg)
`endif

`endif

[rtl/core/slec_pkg.sv]
// shared types, codes and helpers for the sorted list engine core
// no dependencies
`default_nettype none

package slec_pkg;

   localparam int DEPTH_DEF = 32;
   localparam int VAL_W     = 32;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_DELETE    = 2'd1,
      OP_DUMP_ASC  = 2'd2,
      OP_DUMP_DESC = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_INSERTED   = 3'd0,
      STS_DELETED    = 3'd1,
      STS_EMPTY_DEL  = 3'd2,
      STS_NOT_FOUND  = 3'd3,
      STS_FULL       = 3'd4,
      STS_DUMP       = 3'd5,
      STS_EMPTY_DUMP = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_SEEK    = 2'd1,
      S_EMIT    = 2'd2,
      S_RESTORE = 2'd3
   } state_type;

   typedef enum logic [2:0] {
      CMD_HOLD      = 3'd0,
      CMD_INSERT    = 3'd1,
      CMD_DELETE    = 3'd2,
      CMD_ROT_LEFT  = 3'd3,
      CMD_ROT_RIGHT = 3'd4
   } cmd_type;

   typedef struct packed {
      logic             empty;
      logic             full;
      logic             found;
      logic [VAL_W-1:0] head;
   } dp_status_type;

   // sign flip so that an unsigned compare orders signed values
   function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v);
      order_key = {~v[VAL_W-1], v[VAL_W-2:0]};
   endfunction

endpackage

`default_nettype wire

[rtl/core/slec_req_if.sv]
// request channel: valid/ready handshake carrying op and value
// depends on slec_pkg
`default_nettype none

interface slec_req_if;
   logic                      valid;
   logic                      ready;
   slec_pkg::op_type          op;
   logic signed [31:0]        value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

[rtl/core/slec_rsp_if.sv]
// response channel: valid/ready handshake carrying status, entry value and last
// depends on slec_pkg
`default_nettype none

interface slec_rsp_if;
   logic                      valid;
   logic                      ready;
   slec_pkg::status_type      status;
   logic signed [31:0]        entry_value;
   logic                      last;

   modport source (output valid, output status, output entry_value, output last,
                   input ready);
   modport sink   (input valid, input status, input entry_value, input last,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/sorted_list_engine_core.sv]
// sorted list engine core: insert and delete are done at accept, word out on the next cycle
// a dump walks its states in order: ascending accept, emit per entry, restore per entry;
// descending accept, seek to the largest entry, emit per entry, one restore step; the
// cell array rotates one place per step; one word per emit cycle, a held word stalls the walk
// a new request is taken while the last response word waits if the sink takes it that cycle
// synchronous active-high reset clears the entry count and the controller; no clearing pass
`default_nettype none

`include "sorted_list_engine_core_assert.svh"

module sorted_list_engine_core #(
   parameter int  DEPTH = slec_pkg::DEPTH_DEF,
   localparam int CntW  = $clog2(DEPTH + 1)
) (
   input  wire logic   clock,
   input  wire logic   reset,
   slec_req_if.sink    req_if,
   slec_rsp_if.source  rsp_if
);

   // command from controller, status back from the cell array
   slec_pkg::cmd_type       dp_cmd;
   slec_pkg::dp_status_type dp_status;
   logic [CntW-1:0]         dp_count;
   logic                    req_fire;

   assign req_fire = req_if.valid && req_if.ready;

   // cell array: every cell compares against the operand in parallel,
   // shifts for insert and delete, rotates for dumps
   slec_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dp_cmd),
      .operand (req_if.value),
      .status  (dp_status),
      .count   (dp_count)
   );

   // decode, dump walk sequencing and the response word register
   slec_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .dp_status (dp_status),
      .dp_count  (dp_count),
      .cmd       (dp_cmd)
   );

   // entry count never runs past the table size
   `SLEC_ASSERT(a_count_bound, (dp_count <= CntW'(DEPTH)), "entry count exceeds depth")

   // an accepted insert into a table with room grows the count by one
   `SLEC_ASSERT(a_insert_grows,
      (req_fire && req_if.op == slec_pkg::OP_INSERT && !dp_status.full)
         |=> (dp_count == $past(dp_count) + CntW'(1)),
      "insert did not grow count")

   // an accepted delete of a present value shrinks the count by one
   `SLEC_ASSERT(a_delete_shrinks,
      (req_fire && req_if.op == slec_pkg::OP_DELETE && dp_status.found)
         |=> (dp_count == $past(dp_count) - CntW'(1)),
      "delete did not shrink count")

   // reset leaves no response word pending
   `SLEC_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_if.valid, "response valid after reset")

endmodule

`default_nettype wire

[rtl/core/slec_datapath.sv]
// compare-and-shift cell array holding the sorted entries and the entry count
// depends on slec_pkg
`default_nettype none

module slec_datapath #(
   parameter int  DEPTH = slec_pkg::DEPTH_DEF,
   localparam int CntW  = $clog2(DEPTH + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire slec_pkg::cmd_type             cmd,
   input  wire logic [slec_pkg::VAL_W-1:0]    operand,
   output slec_pkg::dp_status_type            status,
   output logic [CntW-1:0]                    count
);

   logic [slec_pkg::VAL_W-1:0] cell_ff [DEPTH];
   logic [slec_pkg::VAL_W-1:0] cell_in [DEPTH];
   logic [CntW-1:0]            count_ff;
   logic [CntW-1:0]            count_in;

   logic [DEPTH-1:0] valid;
   logic [DEPTH-1:0] le;
   logic [DEPTH-1:0] eq;
   logic [DEPTH-1:0] ins_here;
   logic [DEPTH:0]   hit_pre;

   assign hit_pre[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int Nxt = (i + 1) % DEPTH;
      localparam int Prv = (i + DEPTH - 1) % DEPTH;

      assign valid[i] = CntW'(i) < count_ff;
      assign le[i]    = valid[i] && (slec_pkg::order_key(cell_ff[i]) <=
                                     slec_pkg::order_key(operand));
      assign eq[i]    = valid[i] && (cell_ff[i] == operand);
      assign hit_pre[i+1] = hit_pre[i] | eq[i];

      if (i == 0) begin : g_first
         assign ins_here[i] = !le[i];
      end else begin : g_rest
         assign ins_here[i] = !le[i] && le[i-1];
      end

      always_comb begin
         case (cmd)
            slec_pkg::CMD_INSERT: begin
               if (le[i]) cell_in[i] = cell_ff[i];
               else if (ins_here[i]) cell_in[i] = operand;
               else cell_in[i] = cell_ff[Prv];
            end
            slec_pkg::CMD_DELETE: begin
               cell_in[i] = (hit_pre[i] || eq[i]) ? cell_ff[Nxt] : cell_ff[i];
            end
            slec_pkg::CMD_ROT_LEFT:  cell_in[i] = cell_ff[Nxt];
            slec_pkg::CMD_ROT_RIGHT: cell_in[i] = cell_ff[Prv];
            default:                 cell_in[i] = cell_ff[i];
         endcase
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_comb begin
      case (cmd)
         slec_pkg::CMD_INSERT: count_in = count_ff + CntW'(1);
         slec_pkg::CMD_DELETE: count_in = count_ff - CntW'(1);
         default:              count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CntW'(DEPTH));
   assign status.found = hit_pre[DEPTH];
   assign status.head  = cell_ff[0];
   assign count        = count_ff;

endmodule

`default_nettype wire

[rtl/core/slec_ctrl.sv]
// controller: request decode, dump sequencing and the response word register
// depends on slec_pkg, slec_req_if, slec_rsp_if
`default_nettype none

module slec_ctrl #(
   parameter int  DEPTH = slec_pkg::DEPTH_DEF,
   localparam int CntW  = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   slec_req_if.sink                      req_if,
   slec_rsp_if.source                    rsp_if,
   input  wire slec_pkg::dp_status_type  dp_status,
   input  wire logic [CntW-1:0]          dp_count,
   output slec_pkg::cmd_type             cmd
);

   slec_pkg::state_type  state_ff, state_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 desc_ff, desc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   slec_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_free;
   logic                 at_last;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign at_last  = (cnt_ff == dp_count - CntW'(1));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      desc_in       = desc_ff;
      cmd           = slec_pkg::CMD_HOLD;
      req_if.ready  = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         slec_pkg::S_IDLE: begin
            req_if.ready = out_free;
            if (req_if.valid && out_free) begin
               rsp_value_in = req_if.value;
               rsp_last_in  = 1'b1;
               case (req_if.op)
                  slec_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (dp_status.full) begin
                        rsp_status_in = slec_pkg::STS_FULL;
                     end else begin
                        rsp_status_in = slec_pkg::STS_INSERTED;
                        cmd           = slec_pkg::CMD_INSERT;
                     end
                  end
                  slec_pkg::OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (dp_status.empty) begin
                        rsp_status_in = slec_pkg::STS_EMPTY_DEL;
                     end else if (dp_status.found) begin
                        rsp_status_in = slec_pkg::STS_DELETED;
                        cmd           = slec_pkg::CMD_DELETE;
                     end else begin
                        rsp_status_in = slec_pkg::STS_NOT_FOUND;
                     end
                  end
                  slec_pkg::OP_DUMP_ASC, slec_pkg::OP_DUMP_DESC: begin
                     if (dp_status.empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = slec_pkg::STS_EMPTY_DUMP;
                        rsp_value_in  = '0;
                     end else begin
                        desc_in = (req_if.op == slec_pkg::OP_DUMP_DESC);
                        cnt_in  = '0;
                        // descending walk first brings the largest entry to cell 0
                        if (req_if.op == slec_pkg::OP_DUMP_DESC && dp_count > CntW'(1)) begin
                           state_in = slec_pkg::S_SEEK;
                        end else begin
                           state_in = slec_pkg::S_EMIT;
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
                  end
               endcase
            end
         end
         slec_pkg::S_SEEK: begin
            cmd    = slec_pkg::CMD_ROT_LEFT;
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == dp_count - CntW'(2)) begin
               state_in = slec_pkg::S_EMIT;
               cnt_in   = '0;
            end
         end
         slec_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = slec_pkg::STS_DUMP;
               rsp_value_in  = dp_status.head;
               rsp_last_in   = at_last;
               cmd           = desc_ff ? slec_pkg::CMD_ROT_RIGHT : slec_pkg::CMD_ROT_LEFT;
               cnt_in        = cnt_ff + CntW'(1);
               if (at_last) begin
                  state_in = slec_pkg::S_RESTORE;
                  cnt_in   = '0;
               end
            end
         end
         slec_pkg::S_RESTORE: begin
            // undo the net rotation left behind by the walk
            if (desc_ff) begin
               cmd      = slec_pkg::CMD_ROT_LEFT;
               state_in = slec_pkg::S_IDLE;
            end else begin
               cmd    = slec_pkg::CMD_ROT_RIGHT;
               cnt_in = cnt_ff + CntW'(1);
               if (at_last) state_in = slec_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = slec_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slec_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         desc_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         desc_ff      <= desc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.entry_value = rsp_value_ff;
   assign rsp_if.last        = rsp_last_ff;

endmodule

`default_nettype wire

[dv/tb_sorted_list_engine_core.sv]
// testbench for sorted_list_engine_core: directed and random insert, delete and dump words,
// each checked against a shadow sorted list kept in the testbench
// depends on slec_pkg, slec_req_if, slec_rsp_if and sorted_list_engine_core
`default_nettype none

module tb_sorted_list_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = slec_pkg::DEPTH_DEF;
   localparam int REQ_TARGET   = 430;   // request words to plan at the least
   localparam int TAIL_CALM    = 60;    // last request words sent with no idling
   localparam int HOLD_AT      = 60;    // response words seen before the long hold-off
   localparam int HOLD_LEN     = 100;   // long hold-off length in cycles
   localparam int DRAIN_CYCLES = 100;   // quiet cycles after the last response word
   localparam int MAX_PRINTS   = 100;

   typedef struct {
      slec_pkg::op_type   op;
      logic signed [31:0] value;
      bit                 wait_drain;   // hold this word until no response is due
   } req_word_type;

   typedef struct {
      slec_pkg::status_type status;
      logic signed [31:0]   value;
      logic                 last;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset;

   slec_req_if req_bus ();
   slec_rsp_if rsp_bus ();

   sorted_list_engine_core #(.DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // request words waiting to be offered, filled before reset
   req_word_type       req_backlog[$];
   // response words predicted and not yet seen, oldest first
   rsp_word_type       due_rsp[$];
   // shadow of the table, ascending
   logic signed [31:0] shadow_list[$];
   // multiset of values the planner believes present, to aim deletes at real entries
   logic signed [31:0] plan_pool[$];

   int  error_count  = 0;
   int  planned      = 0;
   int  words_sent   = 0;
   int  words_seen   = 0;
   bit  calm_tail    = 1'b0;

   task automatic flag_error(input string what);
      if (error_count < MAX_PRINTS)
         $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // apply one accepted request word to the shadow list and queue its response words
   function automatic void predict_list_op(input slec_pkg::op_type op,
                                           input logic signed [31:0] v);
      int pos;
      int n;
      rsp_word_type w;
      w.value = v;
      w.last  = 1'b1;
      case (op)
         slec_pkg::OP_INSERT: begin
            if (shadow_list.size() >= DEPTH) begin
               w.status = slec_pkg::STS_FULL;
            end else begin
               // new value goes behind any equal entries
               pos = 0;
               while (pos < shadow_list.size() && shadow_list[pos] <= v)
                  pos++;
               shadow_list.insert(pos, v);
               w.status = slec_pkg::STS_INSERTED;
            end
            due_rsp.push_back(w);
         end
         slec_pkg::OP_DELETE: begin
            if (shadow_list.size() == 0) begin
               w.status = slec_pkg::STS_EMPTY_DEL;
            end else begin
               pos = 0;
               while (pos < shadow_list.size() && shadow_list[pos] != v)
                  pos++;
               if (pos >= shadow_list.size()) begin
                  w.status = slec_pkg::STS_NOT_FOUND;
               end else begin
                  shadow_list.delete(pos);
                  w.status = slec_pkg::STS_DELETED;
               end
            end
            due_rsp.push_back(w);
         end
         default: begin
            n = shadow_list.size();
            if (n == 0) begin
               w.status = slec_pkg::STS_EMPTY_DUMP;
               w.value  = '0;
               due_rsp.push_back(w);
            end else begin
               for (int i = 0; i < n; i++) begin
                  w.status = slec_pkg::STS_DUMP;
                  w.value  = (op == slec_pkg::OP_DUMP_ASC) ? shadow_list[i]
                                                           : shadow_list[n - 1 - i];
                  w.last   = (i == n - 1);
                  due_rsp.push_back(w);
               end
            end
         end
      endcase
   endfunction

   // planner side: queue a request word and track what the table should hold
   task automatic plan_req(input slec_pkg::op_type op, input logic signed [31:0] v,
                           input bit drain);
      req_word_type r;
      r.op         = op;
      r.value      = v;
      r.wait_drain = drain;
      req_backlog.push_back(r);
      planned++;
      if (op == slec_pkg::OP_INSERT && plan_pool.size() < DEPTH) begin
         plan_pool.push_back(v);
      end else if (op == slec_pkg::OP_DELETE) begin
         foreach (plan_pool[i]) begin
            if (plan_pool[i] == v) begin
               plan_pool.delete(i);
               break;
            end
         end
      end
   endtask

   // mix of small values (many duplicates), extremes and full-range values
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return 32'(int'($urandom_range(0, 15)) - 8);
      if (r < 6) begin
         case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh8000_0001;
            2: return 32'sh7fff_ffff;
            3: return 32'sh7fff_fffe;
            4: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // mostly values that are present, sometimes ones that are not
   function automatic logic signed [31:0] pick_delete_value();
      if (plan_pool.size() > 0 && $urandom_range(0, 99) < 75)
         return plan_pool[$urandom_range(0, plan_pool.size() - 1)];
      return pick_value();
   endfunction

   // request driver: offers the backlog one word at a time, idling in bursts
   int req_idle_left = 0;

   always @(posedge clock) begin : drive_requests
      req_word_type nxt;
      int           pct;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_list_op(req_bus.op, req_bus.value);
            words_sent++;
         end
         // a word not yet taken stays on the bus unchanged
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (req_idle_left > 0) begin
               req_idle_left--;
               req_bus.valid <= 1'b0;
            end else if (req_backlog.size() > 0 &&
                         (!req_backlog[0].wait_drain || due_rsp.size() == 0)) begin
               nxt = req_backlog.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.op    <= nxt.op;
               req_bus.value <= nxt.value;
               if (req_backlog.size() < TAIL_CALM)
                  calm_tail <= 1'b1;
               // idling rate changes in stretches, including stretches with none
               case ((words_sent / 40) % 3)
                  0: pct = 25;
                  1: pct = 0;
                  default: pct = 50;
               endcase
               if (!calm_tail && $urandom_range(0, 99) < pct)
                  req_idle_left = $urandom_range(1, 8);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each taken word and drives ready
   int  rsp_stall_left = 0;
   int  rsp_hold_left  = 0;
   bit  rsp_hold_done  = 1'b0;

   always @(posedge clock) begin : check_responses
      rsp_word_type w;
      int           pct;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_seen++;
            if (due_rsp.size() == 0) begin
               flag_error($sformatf("unexpected word status %0d value %0d last %0b",
                                    rsp_bus.status, rsp_bus.entry_value, rsp_bus.last));
            end else begin
               w = due_rsp.pop_front();
               if (rsp_bus.status !== w.status)
                  flag_error($sformatf("status %0d, expected %0d",
                                       rsp_bus.status, w.status));
               if (rsp_bus.entry_value !== w.value)
                  flag_error($sformatf("entry_value %0d, expected %0d",
                                       rsp_bus.entry_value, w.value));
               if (rsp_bus.last !== w.last)
                  flag_error($sformatf("last %b, expected %b", rsp_bus.last, w.last));
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!rsp_hold_done && words_seen >= HOLD_AT) begin
            // one long hold-off so the core backs up and stalls its request side
            rsp_hold_done = 1'b1;
            rsp_hold_left = HOLD_LEN - 1;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((words_seen / 100) % 3)
               0: pct = 20;
               1: pct = 0;
               default: pct = 50;
            endcase
            if (!calm_tail && $urandom_range(0, 99) < pct) begin
               rsp_stall_left = $urandom_range(1, 8) - 1;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // stimulus plan, reset and end of run
   initial begin : run_sequence
      int  kind;
      int  phase_no;
      bit  drain;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op    = slec_pkg::OP_INSERT;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;

      // directed: empty table cases
      plan_req(slec_pkg::OP_DUMP_ASC,  32'sh5a5a_5a5a, 1'b0);
      plan_req(slec_pkg::OP_DUMP_DESC, -32'sd1, 1'b0);
      plan_req(slec_pkg::OP_DELETE,    32'sh8000_0000, 1'b0);
      // extremes and duplicates
      plan_req(slec_pkg::OP_INSERT, 32'sh7fff_ffff, 1'b0);
      plan_req(slec_pkg::OP_INSERT, 32'sh8000_0000, 1'b0);
      plan_req(slec_pkg::OP_INSERT, 32'sh0000_0000, 1'b0);
      plan_req(slec_pkg::OP_INSERT, -32'sd1, 1'b0);
      plan_req(slec_pkg::OP_INSERT, 32'sd1, 1'b0);
      plan_req(slec_pkg::OP_INSERT, 32'sh0000_0000, 1'b0);
      plan_req(slec_pkg::OP_INSERT, 32'sh7fff_ffff, 1'b0);
      // operand is ignored by dumps
      plan_req(slec_pkg::OP_DUMP_ASC,  -32'sd1, 1'b0);
      plan_req(slec_pkg::OP_DUMP_DESC, 32'sh7fff_ffff, 1'b0);
      // value absent, one of two equal entries, both ends
      plan_req(slec_pkg::OP_DELETE, 32'sd5, 1'b0);
      plan_req(slec_pkg::OP_DELETE, 32'sh0000_0000, 1'b0);
      plan_req(slec_pkg::OP_DELETE, 32'sh8000_0000, 1'b0);
      plan_req(slec_pkg::OP_DELETE, 32'sh7fff_ffff, 1'b0);
      plan_req(slec_pkg::OP_DUMP_ASC, 32'sh0000_0000, 1'b0);
      // this delete waits until every earlier response is seen
      plan_req(slec_pkg::OP_DELETE, 32'sh0000_0000, 1'b1);
      plan_req(slec_pkg::OP_DELETE, -32'sd1, 1'b0);
      plan_req(slec_pkg::OP_DELETE, 32'sd1, 1'b0);
      plan_req(slec_pkg::OP_DELETE, 32'sh7fff_ffff, 1'b0);
      plan_req(slec_pkg::OP_DELETE, 32'sh0000_0000, 1'b0);
      plan_req(slec_pkg::OP_DUMP_DESC, 32'sh1234_5678, 1'b0);

      // random phases: fill to full, drain to empty, or a mix
      phase_no = 0;
      while (planned < REQ_TARGET) begin
         kind  = (phase_no == 0) ? 0 : $urandom_range(0, 2);
         drain = (phase_no % 3 == 1);
         case (kind)
            0: begin
               while (plan_pool.size() < DEPTH) begin
                  plan_req(slec_pkg::OP_INSERT, pick_value(), drain);
                  drain = 1'b0;
                  if ($urandom_range(0, 11) == 0)
                     plan_req(slec_pkg::op_type'($urandom_range(2, 3)), $urandom, 1'b0);
               end
               // inserts into a full table
               repeat ($urandom_range(1, 3))
                  plan_req(slec_pkg::OP_INSERT, pick_value(), 1'b0);
               plan_req(slec_pkg::op_type'($urandom_range(2, 3)), $urandom, 1'b0);
            end
            1: begin
               while (plan_pool.size() > 0) begin
                  plan_req(slec_pkg::OP_DELETE, pick_delete_value(), drain);
                  drain = 1'b0;
                  if ($urandom_range(0, 11) == 0)
                     plan_req(slec_pkg::op_type'($urandom_range(2, 3)), $urandom, 1'b0);
               end
               // deletes and dump on an empty table
               repeat ($urandom_range(1, 2))
                  plan_req(slec_pkg::OP_DELETE, pick_value(), 1'b0);
               plan_req(slec_pkg::op_type'($urandom_range(2, 3)), $urandom, 1'b0);
            end
            default: begin
               repeat (20) begin
                  case ($urandom_range(0, 19))
                     0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                        plan_req(slec_pkg::OP_INSERT, pick_value(), drain);
                     10, 11, 12, 13, 14, 15, 16:
                        plan_req(slec_pkg::OP_DELETE, pick_delete_value(), drain);
                     default:
                        plan_req(slec_pkg::op_type'($urandom_range(2, 3)), $urandom, drain);
                  endcase
                  drain = 1'b0;
               end
            end
         endcase
         phase_no++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every request word taken, then every response word seen, then a quiet spell
      while (req_backlog.size() > 0 || req_bus.valid)
         @(posedge clock);
      while (due_rsp.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/slec_pkg.sv
rtl/core/slec_req_if.sv
rtl/core/slec_rsp_if.sv
rtl/core/slec_datapath.sv
rtl/core/slec_ctrl.sv
rtl/core/sorted_list_engine_core.sv
dv/tb_sorted_list_engine_core.sv
